>>> sv/spcc_pkg.sv
`timescale 1ns / 1ps

package spcc_pkg;

    localparam int MaxPoints = 4096;

    localparam int CoordW   = 24;
    localparam int SizeW    = 13;
    localparam int GapW     = 23;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = (GapW > SizeW) ? GapW : SizeW;

    localparam int CountW  = $clog2(MaxPoints + 1);
    localparam int SumW    = CoordW + CountW;
    localparam int CmpW    = (CountW > SizeW) ? CountW : SizeW;
    localparam int DiffW   = CoordW;
    localparam int SqW     = 2 * DiffW;
    localparam int DistW   = SqW + 1;
    localparam int ThrW    = 2 * GapW;
    localparam int DivCntW = $clog2(SumW + 1);

    localparam int FifoDepth = 4;
    localparam int FifoAddrW = $clog2(FifoDepth);

    localparam logic [GapW-1:0]  GapReset = GapW'(6554);
    localparam logic [SizeW-1:0] MinReset = SizeW'(3);

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [SumW-1:0]   sum_t;
    typedef logic [CountW-1:0]        count_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAP_THRESHOLD,
        REG_MIN_POINTS
    } cfg_reg_t;

    // One closed cluster that is to be reported.
    typedef struct packed {
        logic   valid;
        sum_t   sum_x;
        sum_t   sum_y;
        count_t count;
    } cluster_t;

    // Everything one point can report: the cluster it closed and the one
    // its scan end flushed.
    typedef struct packed {
        cluster_t first;
        cluster_t second;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

>>> sv/spcc_ifs.sv
`timescale 1ns / 1ps

interface spcc_point_if;
    import spcc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   scan_end;

    modport source (output valid, output point_x, output point_y, output scan_end,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input scan_end,
                  output ready);
endinterface

interface spcc_result_if;
    import spcc_pkg::*;

    logic             valid;
    logic             ready;
    coord_t           center_x;
    coord_t           center_y;
    logic [SizeW-1:0] cluster_size;
    logic             run_last;

    modport source (output valid, output center_x, output center_y,
                    output cluster_size, output run_last, input ready);
    modport sink (input valid, input center_x, input center_y,
                  input cluster_size, input run_last, output ready);
endinterface

>>> sv/spcc_front.sv
`timescale 1ns / 1ps

module spcc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    spcc_point_if.sink                   points,
    input  logic [spcc_pkg::GapW-1:0]    gap_threshold,
    input  logic [spcc_pkg::SizeW-1:0]   min_points,
    input  logic                         q_full,
    output logic                         q_push,
    output spcc_pkg::entry_t             q_data
);
    import spcc_pkg::*;

    logic adv;

    coord_t prev_x_reg;
    coord_t prev_y_reg;

    logic             s1_valid_reg;
    coord_t           s1_x_reg;
    coord_t           s1_y_reg;
    logic             s1_last_reg;
    logic [DiffW-1:0] s1_dx_reg;
    logic [DiffW-1:0] s1_dy_reg;

    logic           s2_valid_reg;
    coord_t         s2_x_reg;
    coord_t         s2_y_reg;
    logic           s2_last_reg;
    logic [SqW-1:0] s2_dx2_reg;
    logic [SqW-1:0] s2_dy2_reg;

    logic            s3_valid_reg;
    coord_t          s3_x_reg;
    coord_t          s3_y_reg;
    logic            s3_last_reg;
    logic            s3_join_reg;

    logic [ThrW-1:0] thr_reg;

    count_t open_count_reg;
    count_t open_count_next;
    sum_t   sum_x_reg;
    sum_t   sum_x_next;
    sum_t   sum_y_reg;
    sum_t   sum_y_next;

    logic signed [CoordW:0] diff_x;
    logic signed [CoordW:0] diff_y;
    logic [DiffW-1:0]       abs_x;
    logic [DiffW-1:0]       abs_y;
    logic [DistW-1:0]       dist_sq;

    cluster_t first_c;
    cluster_t second_c;

    // The whole front moves in lock step; it only holds when the queue is full.
    assign adv          = !q_full;
    assign points.ready = adv;

    assign diff_x = {points.point_x[CoordW-1], points.point_x}
                  - {prev_x_reg[CoordW-1], prev_x_reg};
    assign diff_y = {points.point_y[CoordW-1], points.point_y}
                  - {prev_y_reg[CoordW-1], prev_y_reg};
    assign abs_x  = diff_x[CoordW] ? DiffW'(-diff_x) : DiffW'(diff_x);
    assign abs_y  = diff_y[CoordW] ? DiffW'(-diff_y) : DiffW'(diff_y);

    assign dist_sq = DistW'(s2_dx2_reg) + DistW'(s2_dy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            open_count_reg <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg   <= points.valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            open_count_reg <= open_count_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            if (points.valid)
            begin
                prev_x_reg <= points.point_x;
                prev_y_reg <= points.point_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr_reg <= gap_threshold * gap_threshold;
        if (adv)
        begin
            s1_x_reg    <= points.point_x;
            s1_y_reg    <= points.point_y;
            s1_last_reg <= points.scan_end;
            s1_dx_reg   <= abs_x;
            s1_dy_reg   <= abs_y;

            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            s2_dx2_reg  <= s1_dx_reg * s1_dx_reg;
            s2_dy2_reg  <= s1_dy_reg * s1_dy_reg;

            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_last_reg <= s2_last_reg;
            s3_join_reg <= dist_sq < DistW'(thr_reg);
        end
    end

    // Cluster bookkeeping for the point leaving the last stage.
    always_comb
    begin
        open_count_next = open_count_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        first_c         = '0;
        second_c        = '0;
        if (s3_valid_reg)
        begin
            if (open_count_reg == '0)
            begin
                open_count_next = CountW'(1);
                sum_x_next      = SumW'(s3_x_reg);
                sum_y_next      = SumW'(s3_y_reg);
            end
            else if (s3_join_reg)
            begin
                if (open_count_reg < CountW'(MaxPoints))
                begin
                    open_count_next = open_count_reg + CountW'(1);
                    sum_x_next      = sum_x_reg + SumW'(s3_x_reg);
                    sum_y_next      = sum_y_reg + SumW'(s3_y_reg);
                end
            end
            else
            begin
                first_c.valid   = CmpW'(open_count_reg) >= CmpW'(min_points);
                first_c.sum_x   = sum_x_reg;
                first_c.sum_y   = sum_y_reg;
                first_c.count   = open_count_reg;
                open_count_next = CountW'(1);
                sum_x_next      = SumW'(s3_x_reg);
                sum_y_next      = SumW'(s3_y_reg);
            end

            if (s3_last_reg)
            begin
                second_c.valid  = CmpW'(open_count_next) >= CmpW'(min_points);
                second_c.sum_x  = sum_x_next;
                second_c.sum_y  = sum_y_next;
                second_c.count  = open_count_next;
                open_count_next = '0;
                sum_x_next      = '0;
                sum_y_next      = '0;
            end
        end
    end

    assign q_push        = adv && s3_valid_reg && (first_c.valid || second_c.valid);
    assign q_data.first  = first_c;
    assign q_data.second = second_c;

endmodule

>>> sv/spcc_fifo.sv
`timescale 1ns / 1ps

module spcc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spcc_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output spcc_pkg::entry_t pop_data
);
    import spcc_pkg::*;

    entry_t                mem_reg [FifoDepth];
    logic [FifoAddrW-1:0]  wr_ptr_reg;
    logic [FifoAddrW-1:0]  rd_ptr_reg;
    logic [FifoAddrW:0]    count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full      = count_reg == (FifoAddrW + 1)'(FifoDepth);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/spcc_back.sv
`timescale 1ns / 1ps

module spcc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  spcc_pkg::entry_t q_data,
    output logic             q_pop,
    spcc_result_if.source    results,
    output logic             idle
);
    import spcc_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    cluster_t    pend_reg;
    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic        pend_load;

    logic        load_en;
    logic        load_last;
    cluster_t    load_c;
    logic        step;
    logic        last_step;

    count_t              divisor_reg;
    count_t              size_reg;
    logic                run_last_reg;
    logic [DivCntW-1:0]  div_cnt_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    count_t              rem_x_reg;
    count_t              rem_y_reg;
    logic [SumW-1:0]     quo_x_reg;
    logic [SumW-1:0]     quo_y_reg;
    coord_t              center_x_reg;
    coord_t              center_y_reg;

    logic [SumW-1:0]     mag_x;
    logic [SumW-1:0]     mag_y;
    logic [CountW:0]     trial_x;
    logic [CountW:0]     trial_y;
    logic                ge_x;
    logic                ge_y;
    count_t              rem_x_next;
    count_t              rem_y_next;
    logic [SumW-1:0]     quo_x_next;
    logic [SumW-1:0]     quo_y_next;

    assign last_step = div_cnt_reg == DivCntW'(SumW - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        q_pop           = 1'b0;
        load_en         = 1'b0;
        load_last       = 1'b1;
        load_c          = pend_reg;
        step            = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    load_en         = 1'b1;
                    load_c          = q_data.first.valid ? q_data.first : q_data.second;
                    load_last       = !(q_data.first.valid && q_data.second.valid);
                    pend_load       = 1'b1;
                    pend_valid_next = q_data.first.valid && q_data.second.valid;
                    state_next      = BK_DIV;
                end
            end
            BK_DIV:
            begin
                step = 1'b1;
                if (last_step)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (results.ready)
                begin
                    if (pend_valid_reg)
                    begin
                        load_en         = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = BK_DIV;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Restoring division on magnitudes, one quotient bit per cycle per axis.
    assign mag_x = load_c.sum_x[SumW-1] ? SumW'(-load_c.sum_x) : SumW'(load_c.sum_x);
    assign mag_y = load_c.sum_y[SumW-1] ? SumW'(-load_c.sum_y) : SumW'(load_c.sum_y);

    assign trial_x    = {rem_x_reg, quo_x_reg[SumW-1]};
    assign trial_y    = {rem_y_reg, quo_y_reg[SumW-1]};
    assign ge_x       = trial_x >= {1'b0, divisor_reg};
    assign ge_y       = trial_y >= {1'b0, divisor_reg};
    assign rem_x_next = ge_x ? CountW'(trial_x - {1'b0, divisor_reg}) : CountW'(trial_x);
    assign rem_y_next = ge_y ? CountW'(trial_y - {1'b0, divisor_reg}) : CountW'(trial_y);
    assign quo_x_next = {quo_x_reg[SumW-2:0], ge_x};
    assign quo_y_next = {quo_y_reg[SumW-2:0], ge_y};

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_reg <= q_data.second;
        end
        if (load_en)
        begin
            divisor_reg  <= load_c.count;
            size_reg     <= load_c.count;
            run_last_reg <= load_last;
            div_cnt_reg  <= '0;
            neg_x_reg    <= load_c.sum_x[SumW-1];
            neg_y_reg    <= load_c.sum_y[SumW-1];
            rem_x_reg    <= '0;
            rem_y_reg    <= '0;
            quo_x_reg    <= mag_x;
            quo_y_reg    <= mag_y;
        end
        else if (step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            rem_x_reg   <= rem_x_next;
            rem_y_reg   <= rem_y_next;
            quo_x_reg   <= quo_x_next;
            quo_y_reg   <= quo_y_next;
            if (last_step)
            begin
                center_x_reg <= neg_x_reg ? CoordW'(-quo_x_next) : CoordW'(quo_x_next);
                center_y_reg <= neg_y_reg ? CoordW'(-quo_y_next) : CoordW'(quo_y_next);
            end
        end
    end

    assign results.valid        = state_reg == BK_OUT;
    assign results.center_x     = center_x_reg;
    assign results.center_y     = center_y_reg;
    assign results.cluster_size = SizeW'(size_reg);
    assign results.run_last     = run_last_reg;
    assign idle                 = state_reg == BK_IDLE;

endmodule

>>> sv/scan_point_cluster_centroid_unit.sv
`timescale 1ns / 1ps

// Breakpoint segmentation of one lidar scan with centroid output.
// Points come in on the points channel in scan order; scan_end marks the
// last point of a scan and flushes the open cluster. Each reported cluster
// leaves on the clusters channel as its centroid and point count, and
// run_last marks the last cluster that a given point caused.
// The front takes one point per clock while the queue is not full: three
// pipeline stages form the distance test and update the open cluster, and
// clusters that close go into a four-entry queue. The back divides both
// sums by the count with a restoring divider that makes one quotient bit
// per cycle, then offers the result on the output; it works on one cluster
// at a time while the queue takes further clusters.
// A point that closes a cluster and ends the scan reports up to two
// clusters, those that meet the minimum point count.
// The back pops the queue from its idle state, but loads the second cluster
// of a point straight from its pending register.
// When the receiver stalls, the result is held in the output register, the
// queue fills, and points.ready drops only once the queue is full.
// Reset opens no cluster and loads the register defaults (gap threshold
// 6554, minimum of three points); configuration writes are registered.
module scan_point_cluster_centroid_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    spcc_point_if.sink                     points,
    spcc_result_if.source                  clusters,
    input  logic                           cfg_we,
    input  logic [spcc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [spcc_pkg::CfgDataW-1:0]  cfg_data
);
    import spcc_pkg::*;

    logic [GapW-1:0]  gap_threshold_reg;
    logic [SizeW-1:0] min_points_reg;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    entry_t q_push_data;
    entry_t q_pop_data;
    logic   back_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= GapReset;
            min_points_reg    <= MinReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAP_THRESHOLD: gap_threshold_reg <= cfg_data[GapW-1:0];
                REG_MIN_POINTS:    min_points_reg    <= cfg_data[SizeW-1:0];
                default:           ;
            endcase
        end
    end

    spcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .points        (points),
        .gap_threshold (gap_threshold_reg),
        .min_points    (min_points_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    spcc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    spcc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .results (clusters),
        .idle    (back_idle)
    );

    // The front must never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("cluster queue overflow");

    // With nothing queued and the back idle, no result can appear next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (!q_valid && back_idle) |=> !clusters.valid)
        else $error("result without queued cluster");

    // A result that is not the last of its point is followed by more work.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (clusters.valid && clusters.ready && !clusters.run_last)
                     |=> !back_idle)
        else $error("second cluster of a point was dropped");

endmodule
